>>> hdl/dcc_pkg.sv
// Shared types and constants of the delayed command completion slots block.
// No dependencies; used by dcc_decode, the core and the testbench.
`default_nettype none

package dcc_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CW = $clog2(SLOTS + 1);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_ABORT = 2'd2,
        KIND_RESET = 2'd3
    } kind_t;

    localparam logic [2:0] STAT_GOOD        = 3'd0;
    localparam logic [2:0] STAT_CHECK       = 3'd1;
    localparam logic [2:0] STAT_NO_CONNECT  = 3'd2;
    localparam logic [2:0] STAT_RESET_ABORT = 3'd3;
    localparam logic [2:0] STAT_ABORT       = 3'd4;
    localparam logic [2:0] STAT_NO_SLOT     = 3'd5;

    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] OP_READ6           = 8'h08;
    localparam logic [7:0] OP_WRITE6          = 8'h0a;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MEDIUM_REMOVAL  = 8'h1e;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;
    localparam logic [7:0] OP_WRITE10         = 8'h2a;

    localparam logic [31:0] CHANGE_BLOCK = 32'h0000_fff0;
    localparam logic [2:0]  TARGET_COUNT = 3'd2;
    localparam logic [7:0]  DELAY_RESET  = 8'd10;

    localparam logic [2:0] REG_DELAY = 3'd0;

    typedef struct packed {
        logic        reject;
        logic        sense;
        logic        change;
    } dec_t;

    typedef struct packed {
        logic        check;
        logic [31:0] deadline;
        logic [7:0]  tag;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic        sense_attn;
        logic [7:0]  host_code;
        logic [2:0]  status;
        logic [7:0]  result_tag;
    } res_t;

endpackage

`default_nettype wire

>>> hdl/dcc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/dcc_decode.sv
// Command check and opcode decode: absent target/unit, unknown opcode,
// request sense, and the read of the media change block. Uses dcc_pkg.
`default_nettype none

module dcc_decode (
    input  wire logic [2:0]  target_id,
    input  wire logic [2:0]  lun_number,
    input  wire logic [7:0]  opcode,
    input  wire logic [39:0] cdb_tail,
    output dcc_pkg::dec_t    dec
);

    logic        known;
    logic        is_read6;
    logic        is_read10;
    logic [31:0] block6;

    assign block6 = {11'd0, cdb_tail[36:16]};

    always_comb
    begin
        known     = 1'b0;
        is_read6  = 1'b0;
        is_read10 = 1'b0;
        unique case (opcode)
            dcc_pkg::OP_READ6:
            begin
                known    = 1'b1;
                is_read6 = 1'b1;
            end
            dcc_pkg::OP_READ10:
            begin
                known     = 1'b1;
                is_read10 = 1'b1;
            end
            dcc_pkg::OP_REQUEST_SENSE,
            dcc_pkg::OP_TEST_UNIT_READY,
            dcc_pkg::OP_WRITE6,
            dcc_pkg::OP_INQUIRY,
            dcc_pkg::OP_MEDIUM_REMOVAL,
            dcc_pkg::OP_READ_CAPACITY,
            dcc_pkg::OP_WRITE10:
            begin
                known = 1'b1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dec.reject = (target_id >= dcc_pkg::TARGET_COUNT) || (lun_number != 3'd0) || !known;
        dec.sense  = (opcode == dcc_pkg::OP_REQUEST_SENSE);
        dec.change = (is_read6 && (block6 == dcc_pkg::CHANGE_BLOCK))
                  || (is_read10 && (cdb_tail[31:0] == dcc_pkg::CHANGE_BLOCK));
    end

endmodule

`default_nettype wire

>>> hdl/delayed_command_completion_slots_core.sv
// Delayed command completion slots: top level with slot RAM, sweep FSM and ports.
// Uses dcc_pkg, dcc_decode and dcc_ram.
// A queued command is written to a free slot and the input stays ready; a command with an
// immediate result is held, then moved to the output register in the flush state. Tick,
// abort and reset-all items sweep the slot RAM one slot per cycle unless the output stalls.
// rst_n (async, active low) clears busy bits, tick count and attention flag and sets delay (10).
`default_nettype none

module delayed_command_completion_slots_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] command_tag, [10:8] target_id, [13:11] lun_number, [21:14] opcode,
    // [61:22] cdb_tail, [69:62] abort_code, [71:70] zero
    input  wire logic [71:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] result_tag, [10:8] status, [18:11] host_code, [19] sense_attn,
    // [23:20] zero
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    // APB config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = dcc_pkg::SLOT_AW;
    localparam int CW = dcc_pkg::SLOT_CW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [dcc_pkg::SLOTS-1:0] busy_reg, busy_next;
    logic [31:0]          tick_reg, tick_next;
    logic                 attn_reg, attn_next;
    logic [7:0]           delay_reg, delay_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic [AW-1:0]        eval_idx_reg, eval_idx_next;
    dcc_pkg::kind_t       kind_reg, kind_next;
    logic [7:0]           tag_reg, tag_next;
    logic [7:0]           code_reg, code_next;
    logic                 held_valid_reg, held_valid_next;
    dcc_pkg::res_t        held_reg, held_next;
    logic                 out_valid_reg, out_valid_next;
    dcc_pkg::res_t        out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    dcc_pkg::kind_t       in_kind;
    logic [7:0]           in_tag;
    logic [7:0]           in_code;
    dcc_pkg::dec_t        dec;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    dcc_pkg::slot_t       mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [dcc_pkg::SLOT_W-1:0] mem_rdata;
    dcc_pkg::slot_t       rd_slot;

    logic                 free_found;
    logic [AW-1:0]        free_idx;
    logic                 s_accept;
    logic                 out_free;
    logic [31:0]          diff;
    logic                 due;
    logic                 hit;
    logic                 found;
    logic                 stall;
    logic                 scan_active;
    dcc_pkg::res_t        sweep_res;

    assign in_kind  = dcc_pkg::kind_t'(s_tuser);
    assign in_tag   = s_tdata[7:0];
    assign in_code  = s_tdata[69:62];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};
    assign m_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dcc_pkg::REG_DELAY[0]) ? {24'd0, delay_reg} : 32'd0;

    dcc_decode u_decode (
        .target_id  (s_tdata[10:8]),
        .lun_number (s_tdata[13:11]),
        .opcode     (s_tdata[21:14]),
        .cdb_tail   (s_tdata[61:22]),
        .dec        (dec)
    );

    dcc_ram #(
        .WIDTH (dcc_pkg::SLOT_W),
        .DEPTH (dcc_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_slot = dcc_pkg::slot_t'(mem_rdata);

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = dcc_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    // sweep evaluation of the slot read last cycle
    assign scan_active = (scan_reg < CW'(dcc_pkg::SLOTS));
    assign diff        = rd_slot.deadline - tick_reg;
    assign due         = (diff == 32'd0) || diff[31];

    always_comb
    begin
        sweep_res = '0;
        hit       = 1'b0;
        unique case (kind_reg)
            dcc_pkg::KIND_TICK:
            begin
                hit                  = due;
                sweep_res.result_tag = rd_slot.tag;
                sweep_res.status     = rd_slot.check ? dcc_pkg::STAT_CHECK
                                                     : dcc_pkg::STAT_GOOD;
            end
            dcc_pkg::KIND_ABORT:
            begin
                hit                  = (rd_slot.tag == tag_reg);
                sweep_res.result_tag = tag_reg;
                sweep_res.status     = dcc_pkg::STAT_ABORT;
                sweep_res.host_code  = code_reg;
            end
            dcc_pkg::KIND_RESET:
            begin
                hit                  = 1'b1;
                sweep_res.result_tag = rd_slot.tag;
                sweep_res.status     = dcc_pkg::STAT_RESET_ABORT;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign found     = (state_reg == S_SWEEP) && eval_valid_reg && busy_reg[eval_idx_reg] && hit;
    assign stall     = found && held_valid_reg && !out_free;
    assign mem_raddr = stall ? eval_idx_reg : scan_reg[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        tick_next       = tick_reg;
        attn_next       = attn_reg;
        delay_next      = delay_reg;
        scan_next       = scan_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        kind_next       = kind_reg;
        tag_next        = tag_reg;
        code_next       = code_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata.check    = dec.change;
        mem_wdata.deadline = tick_reg + {24'd0, delay_reg};
        mem_wdata.tag      = in_tag;

        if (psel && penable && pwrite && pready && (paddr[2] == dcc_pkg::REG_DELAY[0]))
        begin
            delay_next = pwdata[7:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    kind_next       = in_kind;
                    tag_next        = in_tag;
                    code_next       = in_code;
                    scan_next       = '0;
                    eval_valid_next = 1'b0;
                    held_next       = '0;
                    held_next.result_tag = in_tag;
                    if (in_kind == dcc_pkg::KIND_CMD)
                    begin
                        priority if (dec.reject)
                        begin
                            held_next.status = dcc_pkg::STAT_NO_CONNECT;
                            held_valid_next  = 1'b1;
                            state_next       = S_FLUSH;
                        end
                        else if (dec.sense)
                        begin
                            held_next.status     = dcc_pkg::STAT_GOOD;
                            held_next.sense_attn = attn_reg;
                            attn_next            = 1'b0;
                            held_valid_next      = 1'b1;
                            state_next           = S_FLUSH;
                        end
                        else if (!free_found)
                        begin
                            held_next.status = dcc_pkg::STAT_NO_SLOT;
                            held_valid_next  = 1'b1;
                            state_next       = S_FLUSH;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            busy_next[free_idx] = 1'b1;
                            if (dec.change)
                            begin
                                attn_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (in_kind == dcc_pkg::KIND_TICK)
                        begin
                            tick_next = tick_reg + 32'd1;
                        end
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (!stall)
                begin
                    if (found)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                            out_last_next  = 1'b0;
                        end
                        held_next               = sweep_res;
                        held_valid_next         = 1'b1;
                        busy_next[eval_idx_reg] = 1'b0;
                    end
                    eval_valid_next = scan_active;
                    eval_idx_next   = scan_reg[AW-1:0];
                    if (scan_active)
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                    else if (!eval_valid_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= '0;
            tick_reg       <= '0;
            attn_reg       <= 1'b0;
            delay_reg      <= dcc_pkg::DELAY_RESET;
            scan_reg       <= '0;
            eval_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            tick_reg       <= tick_next;
            attn_reg       <= attn_next;
            delay_reg      <= delay_next;
            scan_reg       <= scan_next;
            eval_valid_reg <= eval_valid_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        kind_reg     <= kind_next;
        tag_reg      <= tag_next;
        code_reg     <= code_next;
        held_reg     <= held_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // new slots are only claimed while idle
    a_busy_set_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ((busy_reg & ~$past(busy_reg)) == '0))
        else $error("slot claimed during sweep");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !held_valid_reg)
        else $error("input ready with a held request");

    a_eval_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (state_reg == S_SWEEP))
        else $error("slot evaluation outside sweep");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FLUSH) && held_valid_reg && out_free) |=> (m_tvalid && m_tlast))
        else $error("final request not marked last");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for delayed_command_completion_slots_core: a directed request table, then random
// traffic across several completion delays, checked against an in-bench slot table model.
// Depends only on dcc_pkg and the core RTL.

module tb;
    import dcc_pkg::*;

    localparam int         SETTLE      = 3 * SLOTS + 8;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 80;
    localparam int         PHASE_ITEMS = 16;
    localparam int         FLOOD_ITEMS = 24;
    localparam logic [2:0] ADDR_DELAY  = 3'(4 * REG_DELAY);
    localparam logic [2:0] ADDR_SPARE  = 3'(4 * (REG_DELAY + 1));

    typedef struct {
        kind_t       kind;
        logic [7:0]  tag;
        logic [2:0]  target;
        logic [2:0]  lun;
        logic [7:0]  opcode;
        logic [39:0] tail;
        logic [7:0]  abort_code;
        bit          typed;
        logic [2:0]  want_status;
        logic        want_ua;
    } request_t;

    typedef struct packed {
        logic [7:0] tag;
        logic [2:0] status;
        logic [7:0] host;
        logic       ua;
        logic       last;
    } completion_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // row tag for the request on the bus: expectation typed into the table
    logic        cur_typed  = 1'b0;
    logic [2:0]  cur_status = STAT_GOOD;
    logic        cur_ua     = 1'b0;

    // slot table model
    logic        mirror_busy  [SLOTS];
    logic [7:0]  mirror_tag   [SLOTS];
    logic [31:0] mirror_due   [SLOTS];
    logic        mirror_check [SLOTS];
    logic [31:0] mirror_ticks = '0;
    logic        mirror_attn  = 1'b0;
    logic [7:0]  mirror_delay = DELAY_RESET;

    completion_t fresh_q[$];
    completion_t expect_q[$];

    int          mismatches    = 0;
    int          n_requests    = 0;
    int          n_completions = 0;
    int          status_seen [8];
    int          idle_cycles   = 0;

    bit          offering   = 1'b0;
    bit          steady     = 1'b0;
    int          burst_left = 0;

    logic        hold_tgl  = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          rx_mode   = 0;
    int          rx_left   = 0;

    delayed_command_completion_slots_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            mirror_busy[i]  = 1'b0;
            mirror_tag[i]   = '0;
            mirror_due[i]   = '0;
            mirror_check[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
    end

    task automatic flag_mismatch(input string text);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", text);
    endtask

    task automatic stage_completion(input logic [7:0] tag, input logic [2:0] status,
                                    input logic [7:0] host, input logic ua);
        fresh_q.push_back('{tag, status, host, ua, 1'b0});
    endtask

    // completions caused by one request, in order; updates the slot table model
    task automatic resolve_request(input kind_t kind, input logic [71:0] data);
        logic [7:0]  tag;
        logic [2:0]  target;
        logic [2:0]  lun;
        logic [7:0]  opcode;
        logic [39:0] tail;
        logic [7:0]  code;
        logic [31:0] block;
        logic [31:0] margin;
        bit          known;
        bit          is_read;
        bit          sense;
        int          free;
        tag    = data[7:0];
        target = data[10:8];
        lun    = data[13:11];
        opcode = data[21:14];
        tail   = data[61:22];
        code   = data[69:62];
        fresh_q.delete();
        case (kind)
            KIND_CMD:
            begin
                known   = 1'b1;
                is_read = 1'b0;
                sense   = 1'b0;
                block   = '0;
                case (opcode)
                    OP_REQUEST_SENSE:
                        sense = 1'b1;
                    OP_READ6:
                    begin
                        is_read = 1'b1;
                        block   = {11'd0, tail[36:16]};
                    end
                    OP_READ10:
                    begin
                        is_read = 1'b1;
                        block   = tail[31:0];
                    end
                    OP_TEST_UNIT_READY, OP_WRITE6, OP_INQUIRY, OP_MEDIUM_REMOVAL,
                    OP_READ_CAPACITY, OP_WRITE10:
                        ;
                    default:
                        known = 1'b0;
                endcase
                free = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!mirror_busy[i])
                        free = i;
                if (target >= TARGET_COUNT || lun != 3'd0 || !known)
                    stage_completion(tag, STAT_NO_CONNECT, 8'h00, 1'b0);
                else if (sense)
                begin
                    stage_completion(tag, STAT_GOOD, 8'h00, mirror_attn);
                    mirror_attn = 1'b0;
                end
                else if (free < 0)
                    stage_completion(tag, STAT_NO_SLOT, 8'h00, 1'b0);
                else
                begin
                    mirror_busy[free]  = 1'b1;
                    mirror_tag[free]   = tag;
                    mirror_due[free]   = mirror_ticks + 32'(mirror_delay);
                    mirror_check[free] = is_read && block == CHANGE_BLOCK;
                    if (mirror_check[free])
                        mirror_attn = 1'b1;
                end
            end
            KIND_TICK:
            begin
                mirror_ticks = mirror_ticks + 32'd1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    margin = mirror_due[i] - mirror_ticks;
                    if (mirror_busy[i] && (margin == '0 || margin[31]))
                    begin
                        mirror_busy[i] = 1'b0;
                        stage_completion(mirror_tag[i],
                                         mirror_check[i] ? STAT_CHECK : STAT_GOOD, 8'h00, 1'b0);
                    end
                end
            end
            KIND_ABORT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (mirror_busy[i] && mirror_tag[i] == tag)
                    begin
                        mirror_busy[i] = 1'b0;
                        stage_completion(tag, STAT_ABORT, code, 1'b0);
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (mirror_busy[i])
                    begin
                        mirror_busy[i] = 1'b0;
                        stage_completion(mirror_tag[i], STAT_RESET_ABORT, 8'h00, 1'b0);
                    end
                end
            end
        endcase
        if (fresh_q.size() > 0)
            fresh_q[fresh_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk)
    begin : scoreboard
        completion_t want;
        completion_t seen;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen = '{m_tdata[7:0], m_tdata[10:8], m_tdata[18:11], m_tdata[19], m_tlast};
                status_seen[seen.status]++;
                n_completions++;
                if (expect_q.size() == 0)
                    flag_mismatch($sformatf("unexpected completion tag %02h status %0d",
                                            seen.tag, seen.status));
                else
                begin
                    want = expect_q.pop_front();
                    if (seen != want)
                        flag_mismatch($sformatf(
                            "exp/got tag %02h/%02h status %0d/%0d host %02h/%02h ua %0b/%0b last %0b/%0b",
                            want.tag, seen.tag, want.status, seen.status, want.host, seen.host,
                            want.ua, seen.ua, want.last, seen.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                resolve_request(kind_t'(s_tuser), s_tdata);
                n_requests++;
                if (cur_typed)
                    expect_q.push_back('{s_tdata[7:0], cur_status, 8'h00, cur_ua, 1'b1});
                else
                    foreach (fresh_q[i])
                        expect_q.push_back(fresh_q[i]);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_DELAY)
                mirror_delay = pwdata[7:0];
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_tgl != hold_seen)
        begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(8, 60);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no progress for %0d cycles, %0d completions outstanding",
                     idle_cycles, expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_delay_reg(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DELAY;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] != value)
            flag_mismatch($sformatf("delay register exp %0d got %0d", value, prdata[7:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_delay(input logic [7:0] value);
        apb_write(ADDR_DELAY, {24'($urandom), value});
        check_delay_reg(value);
    endtask

    task automatic offer_request(input request_t r);
        int gap;
        s_tvalid   <= 1'b1;
        s_tuser    <= r.kind;
        s_tdata    <= {2'b00, r.abort_code, r.tail, r.opcode, r.lun, r.target, r.tag};
        cur_typed  <= r.typed;
        cur_status <= r.want_status;
        cur_ua     <= r.want_ua;
        offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        gap = 0;
        if (!steady)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
            end
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pauses until every completion is back and the sweep has had time to finish
    task automatic settle_all();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic request_t make_request(
        input kind_t kind, input logic [7:0] tag, input logic [2:0] target,
        input logic [2:0] lun, input logic [7:0] opcode, input logic [39:0] tail,
        input logic [7:0] code, input bit typed, input logic [2:0] status, input logic ua);
        request_t r;
        r.kind        = kind;
        r.tag         = tag;
        r.target      = target;
        r.lun         = lun;
        r.opcode      = opcode;
        r.tail        = tail;
        r.abort_code  = code;
        r.typed       = typed;
        r.want_status = status;
        r.want_ua     = ua;
        return r;
    endfunction

    function automatic logic [7:0] known_op(input int idx);
        case (idx)
            0:       return OP_TEST_UNIT_READY;
            1:       return OP_REQUEST_SENSE;
            2:       return OP_READ6;
            3:       return OP_WRITE6;
            4:       return OP_INQUIRY;
            5:       return OP_MEDIUM_REMOVAL;
            6:       return OP_READ_CAPACITY;
            7:       return OP_READ10;
            default: return OP_WRITE10;
        endcase
    endfunction

    // mostly well-formed commands on a small tag pool so aborts hit; some noise
    function automatic request_t rand_request();
        request_t r;
        int       pick;
        r = make_request(KIND_TICK, 8'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
                         40'({$urandom, $urandom}), 8'($urandom), 1'b0, STAT_GOOD, 1'b0);
        if ($urandom_range(0, 9) < 7)
            r.tag = 8'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            r.kind = KIND_CMD;
            if (pick >= 5)
            begin
                r.target = 3'($urandom_range(0, 1));
                r.lun    = 3'd0;
            end
            if (pick >= 10)
                r.opcode = known_op($urandom_range(0, 8));
            if (pick >= 10 && pick < 16)
            begin
                if (pick % 2 == 0)
                begin
                    r.opcode      = OP_READ6;
                    r.tail[36:16] = 21'(CHANGE_BLOCK);
                end
                else
                begin
                    r.opcode     = OP_READ10;
                    r.tail[31:0] = CHANGE_BLOCK;
                end
            end
        end
        else if (pick < 82)
            r.kind = KIND_TICK;
        else if (pick < 93)
            r.kind = KIND_ABORT;
        else
            r.kind = KIND_RESET;
        return r;
    endfunction

    initial
    begin
        request_t    directed_q[$];
        request_t    r;
        logic [7:0]  phase_delay;

        // delay is 2 during this table
        directed_q.push_back(make_request(KIND_CMD, 8'hff, 3'd7, 3'd0, OP_TEST_UNIT_READY,
                                          '0, 8'h00, 1'b1, STAT_NO_CONNECT, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h00, 3'd0, 3'd7, OP_TEST_UNIT_READY,
                                          '1, 8'hff, 1'b1, STAT_NO_CONNECT, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h5a, 3'd1, 3'd0, 8'hff,
                                          40'h12_3456_789a, 8'h00, 1'b1, STAT_NO_CONNECT, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h01, 3'd0, 3'd0, OP_REQUEST_SENSE,
                                          '0, 8'h00, 1'b1, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_TICK, 8'hff, 3'd7, 3'd7, 8'hff,
                                          '1, 8'hff, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h11, 3'd0, 3'd0, OP_READ6,
                                          40'he0_fff0_0000, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h12, 3'd1, 3'd0, OP_READ10,
                                          40'hff_0000_fff0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h02, 3'd0, 3'd0, OP_REQUEST_SENSE,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h13, 3'd0, 3'd0, OP_WRITE6,
                                          '1, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h14, 3'd1, 3'd0, OP_INQUIRY,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h15, 3'd0, 3'd0, OP_MEDIUM_REMOVAL,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h16, 3'd1, 3'd0, OP_READ_CAPACITY,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h17, 3'd0, 3'd0, OP_WRITE10,
                                          '1, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h13, 3'd1, 3'd0, OP_TEST_UNIT_READY,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        // table full: no slot, and the media change read must not raise attention
        directed_q.push_back(make_request(KIND_CMD, 8'h20, 3'd0, 3'd0, OP_READ10,
                                          40'h00_0000_fff0, 8'h00, 1'b1, STAT_NO_SLOT, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h21, 3'd0, 3'd0, OP_REQUEST_SENSE,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_ABORT, 8'h13, 3'd0, 3'd0, 8'h00,
                                          '0, 8'ha5, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_ABORT, 8'h99, 3'd7, 3'd7, 8'hff,
                                          '1, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_TICK, 8'h00, 3'd0, 3'd0, 8'h00,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_TICK, 8'h00, 3'd0, 3'd0, 8'h00,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h30, 3'd0, 3'd0, OP_WRITE6,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h31, 3'd1, 3'd0, OP_READ6,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_RESET, 8'hc3, 3'd5, 3'd6, 8'h77,
                                          40'haa_5555_aaaa, 8'h3c, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_RESET, 8'h00, 3'd0, 3'd0, 8'h00,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_CMD, 8'h00, 3'd0, 3'd0, OP_TEST_UNIT_READY,
                                          '0, 8'h00, 1'b0, STAT_GOOD, 1'b0));
        directed_q.push_back(make_request(KIND_ABORT, 8'h00, 3'd0, 3'd0, 8'h00,
                                          '0, 8'hff, 1'b0, STAT_GOOD, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_delay_reg(DELAY_RESET);
        program_delay(8'd2);
        foreach (directed_q[i])
            offer_request(directed_q[i]);
        settle_all();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       phase_delay = 8'd1;
                1:       phase_delay = 8'd255;
                2:       phase_delay = 8'd0;
                3:       phase_delay = 8'($urandom_range(3, 40));
                default: phase_delay = DELAY_RESET;
            endcase
            if (p == 4)
                apb_write(ADDR_SPARE, $urandom);
            program_delay(phase_delay);
            if (p == 0)
            begin
                // receiver holds off while absent-target commands pile up
                hold_tgl <= ~hold_tgl;
                steady = 1'b1;
                repeat (FLOOD_ITEMS)
                begin
                    r = rand_request();
                    r.kind   = KIND_CMD;
                    r.target = 3'($urandom_range(2, 7));
                    offer_request(r);
                end
                steady = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                offer_request(rand_request());
                if ($urandom_range(0, 19) == 0)
                    settle_all();
            end
            settle_all();
        end

        $display("Sent %0d requests, checked %0d completions over six delay settings",
                 n_requests, n_completions);
        $display("good %0d, check %0d, no connect %0d, reset %0d, abort %0d, table full %0d",
                 status_seen[STAT_GOOD], status_seen[STAT_CHECK], status_seen[STAT_NO_CONNECT],
                 status_seen[STAT_RESET_ABORT], status_seen[STAT_ABORT],
                 status_seen[STAT_NO_SLOT]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
